// ----- rtl/aligned_index_interpolator_defines.svh -----
// Assertion macros for the aligned index interpolator.
// Depends on nothing; users supply clk and rst_n in scope.
`ifndef ALIGNED_INDEX_INTERPOLATOR_DEFINES_SVH
`define ALIGNED_INDEX_INTERPOLATOR_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define AII_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define AII_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/aii_pkg.sv -----
// Shared types and constants for the aligned index interpolator.
// Used by aii_cell and the top level; depends on nothing.
package aii_pkg;

  localparam int IDX_W = 16;
  localparam int SIZE_W = 17;
  localparam int MAX_ANCHORS_DEF = 64;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD_ANCHOR = 2'd2;
  localparam logic [1:0] ST_BAD_QUERY = 2'd3;

  localparam logic CFG_LEFT_SIZE = 1'b0;
  localparam logic CFG_RIGHT_SIZE = 1'b1;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [IDX_W-1:0] anchor_left;
    logic [IDX_W-1:0] anchor_right;
    logic [IDX_W-1:0] query_index;
    logic             right_by_left;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] mapped_index;
    logic             exact_hit;
    logic [1:0]       status;
  } out_word_t;

  // Search token that walks down the anchor cells.
  typedef struct packed {
    logic             valid;
    logic             fwd;
    logic [IDX_W-1:0] key;
    logic             hit;
    logic [IDX_W-1:0] hv;
    logic             has_p;
    logic [IDX_W-1:0] pk;
    logic [IDX_W-1:0] pv;
    logic             has_n;
    logic [IDX_W-1:0] nk;
    logic [IDX_W-1:0] nv;
  } token_t;

endpackage

// ----- rtl/aligned_index_interpolator.sv -----
// Aligned index interpolator: a row of MAX_ANCHORS anchor cells and one
// rounding divider. Clear, append, cmd 3 and out-of-range queries go from idle
// straight to result hand-off. A query walks the cell row, one cell a cycle,
// then takes a setup step and, when proportional scaling needs it, a multiply
// step, a load step, a bit-serial division and a finish step.
// Depends on aii_pkg, aii_cell and aligned_index_interpolator_defines.svh.
`include "aligned_index_interpolator_defines.svh"
module aligned_index_interpolator #(
  parameter int MAX_ANCHORS = aii_pkg::MAX_ANCHORS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  aii_pkg::in_word_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output aii_pkg::out_word_t         out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [aii_pkg::SIZE_W-1:0] cfg_data
);
  import aii_pkg::*;

  localparam int CNT_W = $clog2(MAX_ANCHORS + 1);
  localparam int CW = SIZE_W + 1;
  localparam int PW = 2 * CW;
  localparam int NW = PW + 1;
  localparam int RW = CW + 2;
  localparam int DCW = $clog2(NW + 1);
  localparam logic [CW:0] SAT_MAX = {{(CW+1-IDX_W){1'b0}}, {IDX_W{1'b1}}};

  typedef enum logic [2:0] {
    S_IDLE, S_CHAIN, S_CALC, S_MUL, S_LOAD, S_DIV, S_FIN, S_OUT
  } state_t;

  state_t            state_r;
  logic [SIZE_W-1:0] left_size_r;
  logic [SIZE_W-1:0] right_size_r;
  logic [CNT_W-1:0]  count_r;
  logic [IDX_W-1:0]  last_l_r;
  logic [IDX_W-1:0]  last_r_r;
  token_t            inj_r;
  out_word_t         res_r;
  out_word_t         out_r;
  logic              out_valid_r;
  logic [CW-1:0]     k_r;
  logic [CW-1:0]     kmax_r;
  logic [CW-1:0]     vmax_r;
  logic [CW-1:0]     base_r;
  logic [PW-1:0]     prod_r;
  logic [NW-1:0]     num_r;
  logic [RW-1:0]     rem_r;
  logic [CW-1:0]     quo_r;
  logic [DCW-1:0]    dcnt_r;

  token_t            tok [MAX_ANCHORS+1];
  token_t            tok_end;
  logic              in_acc;
  logic              out_free;
  logic              wr_ok;

  logic              c_scale;
  logic [CW-1:0]     c_r;
  logic [CW-1:0]     c_k;
  logic [CW-1:0]     c_kmax;
  logic [CW-1:0]     c_vmax;
  logic [CW-1:0]     c_base;
  logic [CW-1:0]     key_x;
  logic [CW-1:0]     pk_x;
  logic [CW-1:0]     pv_x;
  logic [CW-1:0]     nk_x;
  logic [CW-1:0]     nv_x;
  logic [CW-1:0]     ksize_x;
  logic [CW-1:0]     vsize_x;
  logic [RW-1:0]     rem_sh;
  logic [RW-1:0]     den;
  logic [CW:0]       fin_sum;
  logic [IDX_W-1:0]  q_key;
  logic [SIZE_W-1:0] q_ksize;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data = out_r;
  assign cfg_ready = 1'b1;
  assign q_key = in_data.query_index;
  assign q_ksize = in_data.right_by_left ? left_size_r : right_size_r;
  assign wr_ok = in_acc && (in_data.cmd == CMD_APPEND) &&
                 (count_r < CNT_W'(MAX_ANCHORS)) &&
                 ({1'b0, in_data.anchor_left} < left_size_r) &&
                 ({1'b0, in_data.anchor_right} < right_size_r) &&
                 ((count_r == '0) ||
                  ((in_data.anchor_left > last_l_r) && (in_data.anchor_right > last_r_r)));

  assign tok[0] = inj_r;
  genvar gi;
  generate
    for (gi = 0; gi < MAX_ANCHORS; gi++) begin : g_cell
      aii_cell #(.CELL_IDX(gi), .CNT_W(CNT_W)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_ok && (count_r == CNT_W'(gi))),
        .wr_left (in_data.anchor_left),
        .wr_right(in_data.anchor_right),
        .count   (count_r),
        .tok_in  (tok[gi]),
        .tok_out (tok[gi+1])
      );
    end
  endgenerate
  assign tok_end = tok[MAX_ANCHORS];

  always_comb begin
    key_x = CW'(tok_end.key);
    pk_x = CW'(tok_end.pk);
    pv_x = CW'(tok_end.pv);
    nk_x = CW'(tok_end.nk);
    nv_x = CW'(tok_end.nv);
    ksize_x = CW'(tok_end.fwd ? left_size_r : right_size_r);
    vsize_x = CW'(tok_end.fwd ? right_size_r : left_size_r);
    c_scale = 1'b0;
    c_r = '0;
    c_k = '0;
    c_kmax = '0;
    c_vmax = '0;
    c_base = '0;
    if (tok_end.hit) begin
      c_r = CW'(tok_end.hv);
    end else if (tok_end.has_p && tok_end.has_n) begin
      c_k = key_x - pk_x - CW'(1);
      c_kmax = nk_x - pk_x - CW'(2);
      if (nv_x > pv_x + CW'(1)) begin
        c_scale = 1'b1;
        c_vmax = nv_x - pv_x - CW'(2);
        c_base = pv_x + CW'(1);
      end else begin
        c_r = (c_k <= (c_kmax >> 1)) ? pv_x : nv_x;
      end
    end else if (tok_end.has_p) begin
      if (vsize_x > pv_x + CW'(1)) begin
        c_scale = 1'b1;
        c_k = key_x - pk_x - CW'(1);
        c_kmax = ksize_x - pk_x - CW'(2);
        c_vmax = vsize_x - pv_x - CW'(2);
        c_base = pv_x + CW'(1);
      end else begin
        c_r = pv_x;
      end
    end else if (tok_end.has_n) begin
      if (nv_x != '0) begin
        c_scale = 1'b1;
        c_k = key_x;
        c_kmax = nk_x - CW'(1);
        c_vmax = nv_x - CW'(1);
      end
    end else if (vsize_x != '0) begin
      c_scale = 1'b1;
      c_k = key_x;
      c_kmax = ksize_x - CW'(1);
      c_vmax = vsize_x - CW'(1);
    end
    if (c_scale) begin
      if (c_vmax == '0) begin
        c_scale = 1'b0;
        c_r = c_base;
      end else if (c_kmax == '0) begin
        c_scale = 1'b0;
        c_r = c_base + (c_vmax >> 1);
      end else if (c_kmax == c_vmax) begin
        c_scale = 1'b0;
        c_r = c_base + c_k;
      end
    end
  end

  assign rem_sh = {rem_r[RW-2:0], num_r[NW-1]};
  assign den = {1'b0, kmax_r, 1'b0};
  assign fin_sum = {1'b0, quo_r} + {1'b0, base_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_size_r <= SIZE_W'(1);
      right_size_r <= SIZE_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LEFT_SIZE: left_size_r <= cfg_data;
        CFG_RIGHT_SIZE: right_size_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      inj_r <= '0;
      out_valid_r <= 1'b0;
      dcnt_r <= '0;
    end else begin
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            case (in_data.cmd)
              CMD_CLEAR: begin
                count_r <= '0;
                res_r <= '0;
                state_r <= S_OUT;
              end
              CMD_APPEND: begin
                state_r <= S_OUT;
                if (count_r >= CNT_W'(MAX_ANCHORS)) begin
                  res_r <= '{mapped_index: '0, exact_hit: 1'b0, status: ST_FULL};
                end else if (!wr_ok) begin
                  res_r <= '{mapped_index: '0, exact_hit: 1'b0, status: ST_BAD_ANCHOR};
                end else begin
                  res_r <= '0;
                  count_r <= count_r + CNT_W'(1);
                  last_l_r <= in_data.anchor_left;
                  last_r_r <= in_data.anchor_right;
                end
              end
              CMD_QUERY: begin
                if ({1'b0, q_key} >= q_ksize) begin
                  res_r <= '{mapped_index: '0, exact_hit: 1'b0, status: ST_BAD_QUERY};
                  state_r <= S_OUT;
                end else begin
                  res_r <= '0;
                  inj_r <= '{valid: 1'b1, fwd: in_data.right_by_left, key: q_key,
                             default: '0};
                  state_r <= S_CHAIN;
                end
              end
              default: begin
                res_r <= '0;
                state_r <= S_OUT;
              end
            endcase
          end
        end
        S_CHAIN: begin
          inj_r.valid <= 1'b0;
          if (tok_end.valid) begin
            state_r <= S_CALC;
          end
        end
        S_CALC: begin
          k_r <= c_k;
          kmax_r <= c_kmax;
          vmax_r <= c_vmax;
          base_r <= c_base;
          if (c_scale) begin
            state_r <= S_MUL;
          end else begin
            res_r <= '{mapped_index: ({1'b0, c_r} > SAT_MAX) ? {IDX_W{1'b1}} : IDX_W'(c_r),
                       exact_hit: tok_end.hit, status: ST_OK};
            state_r <= S_OUT;
          end
        end
        S_MUL: begin
          prod_r <= k_r * vmax_r;
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          num_r <= {prod_r, 1'b0} + NW'(kmax_r);
          rem_r <= '0;
          quo_r <= '0;
          dcnt_r <= DCW'(NW);
          state_r <= S_DIV;
        end
        S_DIV: begin
          num_r <= {num_r[NW-2:0], 1'b0};
          if (rem_sh >= den) begin
            rem_r <= rem_sh - den;
            quo_r <= {quo_r[CW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            quo_r <= {quo_r[CW-2:0], 1'b0};
          end
          dcnt_r <= dcnt_r - DCW'(1);
          if (dcnt_r == DCW'(1)) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          res_r <= '{mapped_index: (fin_sum > SAT_MAX) ? {IDX_W{1'b1}} : IDX_W'(fin_sum),
                     exact_hit: 1'b0, status: ST_OK};
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_r <= res_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `AII_ASSERT(a_count_max, count_r <= CNT_W'(MAX_ANCHORS), "anchor count beyond table")
  `AII_ASSERT(a_tok_chain, tok_end.valid |-> state_r == S_CHAIN, "token left row outside search")
  `AII_ASSERT(a_div_cnt, (state_r == S_DIV) |-> dcnt_r != '0, "divider counter empty")
  `AII_ASSERT(a_out_idle, (state_r == S_OUT && out_free) |=> out_valid_r, "result not delivered")

endmodule

// ----- rtl/aii_cell.sv -----
// One anchor cell: holds one anchor pair and refines the search token.
// Depends on aii_pkg.
module aii_cell #(
  parameter int CELL_IDX = 0,
  parameter int CNT_W = 7
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   wr_en,
  input  logic [aii_pkg::IDX_W-1:0] wr_left,
  input  logic [aii_pkg::IDX_W-1:0] wr_right,
  input  logic [CNT_W-1:0]       count,
  input  aii_pkg::token_t        tok_in,
  output aii_pkg::token_t        tok_out
);
  import aii_pkg::*;

  logic [IDX_W-1:0] left_r;
  logic [IDX_W-1:0] right_r;
  logic             active;
  logic [IDX_W-1:0] ks;
  logic [IDX_W-1:0] vs;
  token_t           tok_nxt;
  token_t           tok_r;

  assign active = CNT_W'(CELL_IDX) < count;
  assign ks = tok_in.fwd ? left_r : right_r;
  assign vs = tok_in.fwd ? right_r : left_r;

  always_comb begin
    tok_nxt = tok_in;
    if (active && !tok_in.hit) begin
      if (ks == tok_in.key) begin
        tok_nxt.hit = 1'b1;
        tok_nxt.hv = vs;
      end else if (ks < tok_in.key) begin
        tok_nxt.has_p = 1'b1;
        tok_nxt.pk = ks;
        tok_nxt.pv = vs;
      end else if (!tok_in.has_n) begin
        tok_nxt.has_n = 1'b1;
        tok_nxt.nk = ks;
        tok_nxt.nv = vs;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      left_r <= wr_left;
      right_r <= wr_right;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule
